// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/core/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared sizes, opcodes and transaction types of the LFU cache table.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W     = $clog2(NUM_SLOTS + 1);
  localparam int CAP_W     = 5;
  localparam int KEY_W     = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SLOT_W-1:0] LAST_POS  = SLOT_W'(NUM_SLOTS - 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } out_item_t;

  // Move one slot inside the rank order: take it out of from_pos and put it
  // in front of the entry now at to_pos (to_pos == NUM_SLOTS: at the tail).
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] from_pos;
    logic [POS_W-1:0]  to_pos;
  } rank_move_t;

endpackage

// File: rtl/core/lfuc_rank.sv
// ----------------------------------------------------------------------------
// lfuc_rank
// Rank order of the cache slots, best first, with one read port by position
// and a registered move of one slot to a new position.
// ----------------------------------------------------------------------------
module lfuc_rank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lfuc_pkg::SLOT_W-1:0]   rd_pos,
  output logic [lfuc_pkg::SLOT_W-1:0]   rd_slot,
  input  lfuc_pkg::rank_move_t          move
);

  logic [lfuc_pkg::SLOT_W-1:0] rank_r   [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::SLOT_W-1:0] rank_nxt [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::SLOT_W-1:0] up       [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::SLOT_W-1:0] dn       [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::POS_W-1:0]  from_ext;
  logic [lfuc_pkg::POS_W-1:0]  dest;
  logic                        move_back;

  // neighbor taps for the shift of the segment between old and new place
  for (genvar g = 0; g < lfuc_pkg::NUM_SLOTS; g++) begin : g_tap
    if (g < lfuc_pkg::NUM_SLOTS - 1) begin : g_up
      assign up[g] = rank_r[g+1];
    end else begin : g_up_last
      assign up[g] = rank_r[g];
    end
    if (g > 0) begin : g_dn
      assign dn[g] = rank_r[g-1];
    end else begin : g_dn_first
      assign dn[g] = rank_r[g];
    end
  end

  assign from_ext  = lfuc_pkg::POS_W'(move.from_pos);
  assign move_back = move.to_pos > from_ext;
  assign dest      = move.to_pos - lfuc_pkg::POS_W'(1);

  always_comb begin
    for (int i = 0; i < lfuc_pkg::NUM_SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (move.en) begin
        if (move_back) begin
          if (lfuc_pkg::POS_W'(i) == dest) begin
            rank_nxt[i] = move.slot;
          end else if (lfuc_pkg::POS_W'(i) >= from_ext && lfuc_pkg::POS_W'(i) < dest) begin
            rank_nxt[i] = up[i];
          end
        end else begin
          if (lfuc_pkg::POS_W'(i) == move.to_pos) begin
            rank_nxt[i] = move.slot;
          end else if (lfuc_pkg::POS_W'(i) > move.to_pos &&
                       lfuc_pkg::POS_W'(i) <= from_ext) begin
            rank_nxt[i] = dn[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lfuc_pkg::NUM_SLOTS; i++) begin
        rank_r[i] <= lfuc_pkg::SLOT_W'(i);
      end
    end else begin
      rank_r <= rank_nxt;
    end
  end

  assign rd_slot = rank_r[rd_pos];

endmodule

// File: rtl/core/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value cache of 16 slots with least-frequently-used replacement, ties
// going to the least recently used entry. A transaction is taken when start
// is high and busy is low; busy then stays high until the operation is done.
// Every get returns one result, shown on out_item for exactly one cycle with
// out_strobe high, registered when the operation is decided; the receiver cannot
// stall it. A put returns nothing. Each operation scans the slots one per
// cycle through a single key compare and then decides; a get miss or an
// ignored put is then done. A hit or a store also walks the rank order one
// position per cycle and then moves the entry. The capacity register
// is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while busy is low, and the block itself does not enforce this. It takes
// effect at once; slots beyond the new capacity are dropped.
// ----------------------------------------------------------------------------
module lfu_cache_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lfuc_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output lfuc_pkg::out_item_t         out_item,
  input  logic                        cfg_wr_en,
  input  logic [lfuc_pkg::CAP_W-1:0]  cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WALK,
    ST_MOVE
  } state_t;

  state_t                         state_r;
  logic [lfuc_pkg::CAP_W-1:0]     cap_r;
  logic [lfuc_pkg::NUM_SLOTS-1:0] valid_r;
  logic [lfuc_pkg::KEY_W-1:0]     key_r   [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::DATA_W-1:0]    data_r  [lfuc_pkg::NUM_SLOTS];
  logic [lfuc_pkg::CNT_W-1:0]     count_r [lfuc_pkg::NUM_SLOTS];

  lfuc_pkg::in_item_t             req_r;
  logic [lfuc_pkg::SLOT_W-1:0]    idx_r;
  logic                           found_r;
  logic [lfuc_pkg::SLOT_W-1:0]    hit_slot_r;
  logic                           empty_found_r;
  logic [lfuc_pkg::SLOT_W-1:0]    empty_slot_r;
  logic [lfuc_pkg::SLOT_W-1:0]    lastv_slot_r;
  logic [lfuc_pkg::SLOT_W-1:0]    tgt_r;
  logic [lfuc_pkg::CNT_W-1:0]     cnt_s_r;
  logic [lfuc_pkg::SLOT_W-1:0]    q_r;
  logic [lfuc_pkg::POS_W-1:0]     e_r;
  logic                           e_found_r;
  logic                           out_strobe_r;
  lfuc_pkg::out_item_t            out_item_r;

  logic [lfuc_pkg::SLOT_W-1:0]    rank_slot;
  logic [lfuc_pkg::SLOT_W-1:0]    cnt_addr;
  logic [lfuc_pkg::CNT_W-1:0]     cnt_rd;
  logic [lfuc_pkg::CNT_W-1:0]     cnt_inc;
  logic                           key_match;
  logic                           in_cap;
  logic [lfuc_pkg::SLOT_W-1:0]    new_slot;
  lfuc_pkg::rank_move_t           move;

  lfuc_rank u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_pos  (idx_r),
    .rd_slot (rank_slot),
    .move    (move)
  );

  // one count read port: hit slot while deciding, ranked slot while walking
  assign cnt_addr  = (state_r == ST_WALK) ? rank_slot : hit_slot_r;
  assign cnt_rd    = count_r[cnt_addr];
  assign cnt_inc   = (cnt_rd == lfuc_pkg::COUNT_MAX) ? cnt_rd
                                                     : cnt_rd + lfuc_pkg::CNT_W'(1);
  assign key_match = valid_r[idx_r] && (key_r[idx_r] == req_r.key);
  assign in_cap    = int'(idx_r) < int'(cap_r);
  // all slots in use are full when no empty one was seen: evict last valid in rank
  assign new_slot  = empty_found_r ? empty_slot_r : lastv_slot_r;

  assign move.en       = (state_r == ST_MOVE);
  assign move.slot     = tgt_r;
  assign move.from_pos = q_r;
  assign move.to_pos   = e_found_r ? e_r : lfuc_pkg::POS_W'(lfuc_pkg::NUM_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= lfuc_pkg::CAP_RESET;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;

      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
        for (int i = 0; i < lfuc_pkg::NUM_SLOTS; i++) begin
          if (i >= int'(cfg_wr_data)) begin
            valid_r[i] <= 1'b0;
          end
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r         <= in_item;
            idx_r         <= '0;
            found_r       <= 1'b0;
            empty_found_r <= 1'b0;
            state_r       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (key_match && !found_r) begin
            found_r    <= 1'b1;
            hit_slot_r <= idx_r;
          end
          if (!valid_r[idx_r] && in_cap && !empty_found_r) begin
            empty_found_r <= 1'b1;
            empty_slot_r  <= idx_r;
          end
          // same cycle, walk the rank order for the last valid entry
          if (valid_r[rank_slot]) begin
            lastv_slot_r <= rank_slot;
          end
          if (idx_r == lfuc_pkg::LAST_POS) begin
            state_r <= ST_DECIDE;
          end else begin
            idx_r <= idx_r + lfuc_pkg::SLOT_W'(1);
          end
        end

        ST_DECIDE: begin
          idx_r     <= '0;
          e_found_r <= 1'b0;
          if (req_r.op == lfuc_pkg::OP_GET) begin
            out_strobe_r          <= 1'b1;
            out_item_r.hit        <= found_r;
            out_item_r.read_value <= found_r ? data_r[hit_slot_r] : '0;
          end
          if (found_r) begin
            if (req_r.op == lfuc_pkg::OP_PUT) begin
              data_r[hit_slot_r] <= req_r.value;
            end
            count_r[hit_slot_r] <= cnt_inc;
            cnt_s_r             <= cnt_inc;
            tgt_r               <= hit_slot_r;
            state_r             <= ST_WALK;
          end else if (req_r.op == lfuc_pkg::OP_PUT && cap_r != '0) begin
            valid_r[new_slot] <= 1'b1;
            key_r[new_slot]   <= req_r.key;
            data_r[new_slot]  <= req_r.value;
            count_r[new_slot] <= '0;
            cnt_s_r           <= '0;
            tgt_r             <= new_slot;
            state_r           <= ST_WALK;
          end else begin
            state_r <= ST_IDLE;
          end
        end

        ST_WALK: begin
          if (rank_slot == tgt_r) begin
            q_r <= idx_r;
          end else if (valid_r[rank_slot] && cnt_rd <= cnt_s_r && !e_found_r) begin
            // first valid entry not above the target: target goes in front of it
            e_found_r <= 1'b1;
            e_r       <= lfuc_pkg::POS_W'(idx_r);
          end
          if (idx_r == lfuc_pkg::LAST_POS) begin
            state_r <= ST_MOVE;
          end else begin
            idx_r <= idx_r + lfuc_pkg::SLOT_W'(1);
          end
        end

        ST_MOVE: begin
          state_r <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: rtl/core/lfuc_checker.sv
// ----------------------------------------------------------------------------
// lfuc_checker
// Port-level checks of the LFU cache table, bound to lfu_cache_table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfuc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input lfuc_pkg::out_item_t out_item
);

  // a taken transaction makes the block busy
  `ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)

  // result strobes never come on adjacent cycles
  `ASSERT_NXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)

  // a result follows a busy cycle
  `ASSERT_IMP(a_strobe_after_busy, clk, rst_n, out_strobe, $past(busy))

  // a miss reads as zero
  `ASSERT_IMP(a_miss_zero, clk, rst_n, out_strobe && !out_item.hit, out_item.read_value == '0)

endmodule

bind lfu_cache_table lfuc_checker u_lfuc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// File: tb/lfu_tb_pkg.sv
// ----------------------------------------------------------------------------
// lfu_tb_pkg
// Scoreboard of the LFU cache table: keeps its own copy of the slot table
// and rank order, works out each get's read result and checks the block's
// results in order.
// ----------------------------------------------------------------------------
package lfu_tb_pkg;

  import lfuc_pkg::*;

  class lfu_checker;
    bit                slot_used [NUM_SLOTS];
    logic [KEY_W-1:0]  slot_key  [NUM_SLOTS];
    logic [DATA_W-1:0] slot_word [NUM_SLOTS];
    logic [CNT_W-1:0]  slot_uses [NUM_SLOTS];
    int                rank      [NUM_SLOTS];
    int                active;
    out_item_t         expected_reads [$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_word[i] = '0;
        slot_uses[i] = '0;
        rank[i]      = i;
      end
      active = NUM_SLOTS;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10)
        $display("%0t ns: %s", $time, msg);
    endfunction

    // Put slot s ahead of every entry whose count does not exceed its own.
    function void promote(int s);
      int rest [NUM_SLOTS];
      int n;
      int p;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (rank[i] != s) begin
          rest[n] = rank[i];
          n++;
        end
      end
      p = 0;
      while (p < n && slot_used[rest[p]] && slot_uses[rest[p]] > slot_uses[s])
        p++;
      for (int i = 0; i < p; i++)
        rank[i] = rest[i];
      rank[p] = s;
      for (int i = p; i < n; i++)
        rank[i + 1] = rest[i];
    endfunction

    function void bump(int s);
      if (slot_uses[s] != COUNT_MAX)
        slot_uses[s] = slot_uses[s] + 1'b1;
      promote(s);
    endfunction

    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_used[i] && slot_key[i] == key)
          return i;
      return -1;
    endfunction

    // Slots beyond the new size are dropped; survivors keep their order in the rank.
    function void set_capacity(logic [CAP_W-1:0] cap);
      int keep [NUM_SLOTS];
      int n;
      active = (cap > NUM_SLOTS) ? NUM_SLOTS : int'(cap);
      for (int i = active; i < NUM_SLOTS; i++)
        slot_used[i] = 1'b0;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_used[rank[i]]) begin
          keep[n] = rank[i];
          n++;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_used[rank[i]]) begin
          keep[n] = rank[i];
          n++;
        end
      end
      rank = keep;
    endfunction

    function void take_request(in_item_t it);
      int        s;
      int        t;
      out_item_t r;
      s = find_slot(it.key);
      if (it.op == OP_GET) begin
        r.hit        = (s >= 0);
        r.read_value = (s >= 0) ? slot_word[s] : '0;
        expected_reads.push_back(r);
        if (s >= 0)
          bump(s);
        return;
      end
      if (s >= 0) begin
        slot_word[s] = it.value;
        bump(s);
        return;
      end
      if (active == 0)
        return;
      t = -1;
      for (int i = 0; i < active; i++)
        if (!slot_used[i] && t < 0)
          t = i;
      // table full: victim is the last valid entry in rank order
      if (t < 0) begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_used[rank[i]])
            t = rank[i];
      end
      slot_used[t] = 1'b1;
      slot_key[t]  = it.key;
      slot_word[t] = it.value;
      slot_uses[t] = '0;
      promote(t);
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      if (expected_reads.size() == 0) begin
        report($sformatf("unexpected read result: hit %0b value %08h",
                         got.hit, got.read_value));
        return;
      end
      want = expected_reads.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit mismatch: expected %0b, got %0b", want.hit, got.hit));
      if (got.read_value !== want.read_value)
        report($sformatf("read_value mismatch: expected %08h, got %08h",
                         want.read_value, got.read_value));
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression of lfu_cache_table: directed gets and puts over key and value
// extremes, evictions, ties, saturated and reduced capacity, then random
// phases at several capacities with random gaps, bursts and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfuc_pkg::*;
  import lfu_tb_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEMS_PER_PHASE = 165;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_strobe;
  out_item_t          out_item;
  logic               cfg_wr_en;
  logic [CAP_W-1:0]   cfg_wr_data;

  lfu_checker chk;
  bit         burst;
  int         idle_cycles;

  lfu_cache_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      chk.check_read(out_item);
  end

  // watchdog: cycles with no transaction in either direction
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_strobe))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("lfu_cache_table regression: fail");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [KEY_W-1:0] key,
                      input logic [DATA_W-1:0] value, input bit drain);
    in_item_t it;
    int       gap;
    it.op    = op;
    it.key   = key;
    it.value = value;
    if ($urandom_range(0, 24) == 0)
      burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (drain && gap == 0)
      gap = 1;
    if (gap > 0)
      start <= 1'b0;
    if (drain)
      while (chk.expected_reads.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    chk.take_request(it);
  endtask

  // puts leave no result behind, so let the last one finish before writing
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (chk.expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    chk.set_capacity(cap);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] pool [$];
    int               cap_plan [$];
    int               active;
    int unsigned      pick;
    logic [KEY_W-1:0] key;

    chk         = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    burst       = 1'b0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_capacity(CAP_W'(16));
    send(OP_GET, 16'h0000, 32'h0000_0000, 1'b0);
    send(OP_PUT, 16'h0000, 32'h0000_0000, 1'b0);
    send(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send(OP_GET, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    send(OP_GET, 16'hFFFF, 32'h0000_0000, 1'b0);
    send(OP_PUT, 16'hFFFF, 32'hA5A5_5A5A, 1'b0);
    send(OP_GET, 16'hFFFF, 32'h0000_0000, 1'b0);
    send(OP_GET, 16'h1234, 32'h0000_0000, 1'b0);

    // two slots, lowest count goes first
    write_capacity(CAP_W'(2));
    send(OP_PUT, 16'h0007, 32'h1111_0007, 1'b0);
    send(OP_GET, 16'h0000, 32'h0000_0000, 1'b0);
    send(OP_PUT, 16'h0008, 32'h2222_0008, 1'b0);
    send(OP_GET, 16'hFFFF, 32'h0000_0000, 1'b0);

    // zero capacity empties the table and ignores puts
    write_capacity(CAP_W'(0));
    send(OP_PUT, 16'h0042, 32'h3333_0042, 1'b0);
    send(OP_GET, 16'h0042, 32'h0000_0000, 1'b0);

    // equal counts: the older entry is evicted
    write_capacity(CAP_W'(2));
    send(OP_PUT, 16'h00A0, 32'h4444_00A0, 1'b0);
    send(OP_PUT, 16'h00A1, 32'h4444_00A1, 1'b0);
    send(OP_PUT, 16'h00A2, 32'h4444_00A2, 1'b0);
    send(OP_GET, 16'h00A0, 32'h0000_0000, 1'b0);
    send(OP_GET, 16'h00A1, 32'h0000_0000, 1'b0);

    // oversized capacity saturates, then shrink drops the upper slots
    write_capacity(CAP_W'(31));
    send(OP_PUT, 16'h00A3, 32'h5555_00A3, 1'b0);
    send(OP_GET, 16'h00A3, 32'h0000_0000, 1'b0);
    write_capacity(CAP_W'(1));
    send(OP_GET, 16'h00A1, 32'h0000_0000, 1'b0);
    send(OP_GET, 16'h00A2, 32'h0000_0000, 1'b0);

    cap_plan = '{16, 1, 31, 3, 16, 0, 8, 2, 16, 5, 20};
    cap_plan.push_back($urandom_range(1, 31));
    foreach (cap_plan[ph]) begin
      write_capacity(CAP_W'(cap_plan[ph]));
      active = (cap_plan[ph] > NUM_SLOTS) ? NUM_SLOTS : cap_plan[ph];
      pool.delete();
      repeat (active + 3) pool.push_back(KEY_W'($urandom));
      repeat ((active == 0) ? 40 : ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        // mostly a small key set so gets hit and the table churns
        if (pick < 85)
          key = pool[$urandom_range(0, pool.size() - 1)];
        else if (pick < 90)
          key = pick[0] ? '1 : '0;
        else
          key = KEY_W'($urandom);
        send(1'($urandom_range(0, 1)), key, $urandom, $urandom_range(0, 79) == 0);
      end
    end

    start <= 1'b0;
    while (chk.expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.errors == 0 && chk.expected_reads.size() == 0)
      $display("lfu_cache_table regression: pass");
    else
      $display("lfu_cache_table regression: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lfuc_pkg.sv
rtl/core/lfuc_rank.sv
rtl/core/lfu_cache_table.sv
rtl/core/lfuc_checker.sv
tb/lfu_tb_pkg.sv
tb/tb_top.sv
